[rtl/core/bff_pkg.sv]
// ----------------------------------------------------------------------------
// bff_pkg
// Types, constants and helpers shared by the bounded frame FIFO.
// ----------------------------------------------------------------------------
package bff_pkg;

	localparam int NUM_SLOTS  = 16;
	localparam int SLOT_BYTES = 256;

	localparam int SLOT_W  = $clog2(NUM_SLOTS);
	localparam int OFF_W   = $clog2(SLOT_BYTES);
	localparam int LEN_W   = OFF_W + 1;
	localparam int CNT_W   = SLOT_W + 1;
	localparam int ADDR_W  = SLOT_W + OFF_W;
	localparam int STORE_DEPTH = NUM_SLOTS * SLOT_BYTES;

	localparam int CFG_FRAMES_W = 5;
	localparam int CFG_BYTES_W  = 9;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_COMMITTED = 3'd1,
		ST_TOO_LONG  = 3'd2,
		ST_FULL      = 3'd3,
		ST_DISCARDED = 3'd4,
		ST_POPPED    = 3'd5,
		ST_EMPTY     = 3'd6
	} status_t;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] out_byte;
		logic       end_of_frame;
		logic [8:0] frame_length;
		logic [4:0] frames_held;
		logic       queue_empty;
	} result_t;

	// work handed from the front end to the storage back end
	typedef struct packed {
		logic              wr;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
		status_t           status;
		logic              eof;
		logic [LEN_W-1:0]  flen;
		logic [CNT_W-1:0]  frames_held;
	} job_t;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		next_slot = (s == SLOT_W'(NUM_SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

endpackage

[rtl/core/bff_ram.sv]
// ----------------------------------------------------------------------------
// bff_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bff_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[rtl/core/bff_front.sv]
// ----------------------------------------------------------------------------
// bff_front
// Classifies push/pop requests, keeps frame bookkeeping, issues storage jobs.
// ----------------------------------------------------------------------------
module bff_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  bff_pkg::item_t                        item,
	input  logic [bff_pkg::CFG_FRAMES_W-1:0]      max_frames,
	input  logic [bff_pkg::CFG_BYTES_W-1:0]       max_frame_bytes,
	output bff_pkg::job_t                         job
);
	import bff_pkg::*;

	logic [SLOT_W-1:0] head_q, tail_q, head_n, tail_n;
	logic [CNT_W-1:0]  count_q, count_n;
	logic [LEN_W-1:0]  wr_off_q, wr_off_n;
	logic [OFF_W-1:0]  rd_off_q, rd_off_n;
	logic              drop_long_q, drop_long_n;
	logic              drop_full_q, drop_full_n;
	logic [LEN_W-1:0]  len_q [NUM_SLOTS];
	logic              len_we;

	logic [CNT_W-1:0]  lim_frames;
	logic [LEN_W-1:0]  lim_bytes;
	logic              first;
	logic [LEN_W-1:0]  head_len;

	always_comb begin
		lim_frames = (CNT_W'(max_frames) > CNT_W'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS)
			: CNT_W'(max_frames);
		lim_bytes  = (LEN_W'(max_frame_bytes) > LEN_W'(SLOT_BYTES)) ? LEN_W'(SLOT_BYTES)
			: LEN_W'(max_frame_bytes);
		first      = (wr_off_q == '0) && !drop_long_q && !drop_full_q;
		head_len   = len_q[head_q];

		head_n      = head_q;
		tail_n      = tail_q;
		count_n     = count_q;
		wr_off_n    = wr_off_q;
		rd_off_n    = rd_off_q;
		drop_long_n = drop_long_q;
		drop_full_n = drop_full_q;
		len_we      = 1'b0;

		job.wr     = 1'b0;
		job.addr   = {tail_q, wr_off_q[OFF_W-1:0]};
		job.wdata  = item.data_byte;
		job.status = ST_EMPTY;
		job.eof    = 1'b0;
		job.flen   = '0;

		if (item.op == OP_PUSH) begin
			drop_full_n = drop_full_q | (first && (count_q >= lim_frames));
			if (!drop_full_n && !drop_long_q) begin
				if (wr_off_q >= lim_bytes) begin
					drop_long_n = 1'b1;
				end else begin
					job.wr   = 1'b1;
					wr_off_n = wr_off_q + 1'b1;
				end
			end
			if (!item.last_byte) begin
				job.status = (drop_full_n || drop_long_n) ? ST_DISCARDED : ST_ACCEPTED;
			end else begin
				if (drop_full_n) begin
					job.status = ST_FULL;
				end else if (drop_long_n) begin
					job.status = ST_TOO_LONG;
				end else begin
					len_we     = 1'b1;
					job.flen   = wr_off_n;
					tail_n     = next_slot(tail_q);
					count_n    = count_q + 1'b1;
					job.status = ST_COMMITTED;
				end
				drop_full_n = 1'b0;
				drop_long_n = 1'b0;
				wr_off_n    = '0;
			end
		end else begin
			job.addr = {head_q, rd_off_q};
			if (count_q != '0) begin
				job.status = ST_POPPED;
				job.flen   = head_len;
				if (({1'b0, rd_off_q} + LEN_W'(1)) >= head_len) begin
					job.eof  = 1'b1;
					rd_off_n = '0;
					head_n   = next_slot(head_q);
					count_n  = count_q - 1'b1;
				end else begin
					rd_off_n = rd_off_q + 1'b1;
				end
			end
		end
		job.frames_held = count_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			wr_off_q    <= '0;
			rd_off_q    <= '0;
			drop_long_q <= 1'b0;
			drop_full_q <= 1'b0;
		end else if (accept) begin
			head_q      <= head_n;
			tail_q      <= tail_n;
			count_q     <= count_n;
			wr_off_q    <= wr_off_n;
			rd_off_q    <= rd_off_n;
			drop_long_q <= drop_long_n;
			drop_full_q <= drop_full_n;
		end
	end

	// lengths are undefined until a frame commits into the slot
	always_ff @(posedge clk) begin
		if (accept && len_we) begin
			len_q[tail_q] <= job.flen;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(NUM_SLOTS))
		else $error("frame count above slot count");

	a_one_drop_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!(drop_full_q && drop_long_q))
		else $error("two drop reasons at once");

	a_full_stores_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		drop_full_q |-> (wr_off_q == '0))
		else $error("bytes stored for a frame dropped as full");

endmodule

[rtl/core/bff_queue.sv]
// ----------------------------------------------------------------------------
// bff_queue
// Two-entry job queue between the front end and the storage back end.
// ----------------------------------------------------------------------------
module bff_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bff_pkg::job_t  push_job,
	input  logic           pop,
	output bff_pkg::job_t  pop_job,
	output logic           full,
	output logic           empty
);
	import bff_pkg::*;

	job_t       entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign pop_job = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job queue underflow");

endmodule

[rtl/core/bff_back.sv]
// ----------------------------------------------------------------------------
// bff_back
// Storage back end: runs queued jobs against the frame store, emits results.
// ----------------------------------------------------------------------------
module bff_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_avail,
	input  bff_pkg::job_t  job,
	output logic           job_take,
	output logic           done,
	output bff_pkg::result_t result
);
	import bff_pkg::*;

	logic       valid_s1;
	job_t       job_s1;
	logic [7:0] rdata;

	assign job_take = job_avail;

	bff_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_frame_store (
		.clk   (clk),
		.we    (job_take && job.wr),
		.addr  (job.addr),
		.wdata (job.wdata),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= job_take;
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			job_s1 <= job;
		end
	end

	always_comb begin
		done                = valid_s1;
		result.status       = job_s1.status;
		result.out_byte     = (job_s1.status == ST_POPPED) ? rdata : 8'h00;
		result.end_of_frame = job_s1.eof;
		result.frame_length = 9'(job_s1.flen);
		result.frames_held  = 5'(job_s1.frames_held);
		result.queue_empty  = (job_s1.frames_held == '0);
	end

endmodule

[rtl/core/bounded_frame_fifo.sv]
// ----------------------------------------------------------------------------
// bounded_frame_fifo
// Queue of variable-length byte frames in fixed slots, with APB limits.
// ----------------------------------------------------------------------------
// An accepted request's job is registered in the job queue, then taken by the back end;
// its done strobe comes with the registered frame store read and result stage.
// Throughput: one request per cycle; the back end drains one job each cycle,
// so the job queue never holds more than one job and busy stays low.
// Reset: clears slot pointers, counts and drop flags, limits go to 16 and 256;
// frame store and length contents are undefined until written. No stall on done.
module bounded_frame_fifo (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  bff_pkg::item_t          item,
	output logic                    done,
	output bff_pkg::result_t        result,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import bff_pkg::*;

	localparam logic REG_MAX_FRAMES = 1'b0;
	localparam logic REG_MAX_BYTES  = 1'b1;

	logic [CFG_FRAMES_W-1:0] max_frames_q;
	logic [CFG_BYTES_W-1:0]  max_bytes_q;
	logic                    cfg_wr;
	logic                    accept;
	logic                    q_full, q_empty, q_pop;
	job_t                    front_job, back_job;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frames_q <= CFG_FRAMES_W'(16);
			max_bytes_q  <= CFG_BYTES_W'(256);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MAX_FRAMES: max_frames_q <= pwdata[CFG_FRAMES_W-1:0];
				REG_MAX_BYTES:  max_bytes_q  <= pwdata[CFG_BYTES_W-1:0];
				default:        max_frames_q <= max_frames_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MAX_FRAMES: prdata = 32'(max_frames_q);
			REG_MAX_BYTES:  prdata = 32'(max_bytes_q);
			default:        prdata = '0;
		endcase
	end

	assign busy   = q_full;
	assign accept = start && !busy;

	bff_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.item            (item),
		.max_frames      (max_frames_q),
		.max_frame_bytes (max_bytes_q),
		.job             (front_job)
	);

	bff_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_job (front_job),
		.pop      (q_pop),
		.pop_job  (back_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	bff_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_avail (!q_empty),
		.job       (back_job),
		.job_take  (q_pop),
		.done      (done),
		.result    (result)
	);

endmodule
